// ----- rtl/core/tfc_pkg.sv -----
package tfc_pkg;

    localparam int MAX_INT_BYTES = 16;
    localparam int CREDIT_SPAN   = 128;

    typedef enum logic [1:0] {
        CMD_CREDIT = 2'd0,
        CMD_ACK    = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_INTR   = 2'd3
    } cmd_t;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_INT  = 2'd1;

    localparam logic [1:0] MOD_XOFF = 2'd1;
    localparam logic [1:0] MOD_XON  = 2'd2;

    localparam logic [1:0] FLOW_SEG = 2'd1;
    localparam logic [1:0] FLOW_MSG = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_CREDIT = 3'd1;
    localparam logic [2:0] ST_IGNORED    = 3'd2;
    localparam logic [2:0] ST_BLOCKED    = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;

    localparam logic REG_FLOW_MODE   = 1'b0;
    localparam logic REG_WINDOW_SIZE = 1'b1;

    localparam logic [1:0] FLOW_MODE_RESET   = 2'd0;
    localparam logic [7:0] WINDOW_SIZE_RESET = 8'd8;

    typedef struct packed {
        logic [1:0] flow_mode;
        logic [7:0] window_size;
    } cfg_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [1:0]        kind;
        logic signed [7:0] delta;
        logic              delta_neg;
        logic [1:0]        modifier;
        logic [31:0]       acked;
        logic [31:0]       seg;
        logic [31:0]       msg;
        logic              is_data;
        logic [31:0]       base;
        logic              queue_empty;
        logic              too_long;
    } item_t;

    typedef struct packed {
        logic        allowed;
        logic [2:0]  status;
        logic [31:0] seg_limit;
        logic [31:0] msg_limit;
        logic [31:0] int_limit;
        logic        xon;
    } result_t;

endpackage

// ----- rtl/core/tfc_front.sv -----
module tfc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        command,
    input  logic [1:0]        credit_kind,
    input  logic signed [7:0] credit_delta,
    input  logic [1:0]        credit_modifier,
    input  logic [31:0]       acked_segment,
    input  logic [31:0]       segment_count,
    input  logic [31:0]       message_count,
    input  logic              is_data,
    input  logic [31:0]       window_base,
    input  logic              queue_empty,
    input  logic [15:0]       interrupt_length,
    input  logic              deq,
    output logic              item_valid,
    output tfc_pkg::item_t    item
);

    tfc_pkg::item_t mem_reg [2];
    tfc_pkg::item_t incoming;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           enq;
    logic           take;

    always_comb
    begin
        incoming.cmd         = tfc_pkg::cmd_t'(command);
        incoming.kind        = credit_kind;
        incoming.delta       = credit_delta;
        incoming.delta_neg   = credit_delta[7];
        incoming.modifier    = credit_modifier;
        incoming.acked       = acked_segment;
        incoming.seg         = segment_count;
        incoming.msg         = message_count;
        incoming.is_data     = is_data;
        incoming.base        = window_base;
        incoming.queue_empty = queue_empty;
        incoming.too_long    = (interrupt_length > 16'(tfc_pkg::MAX_INT_BYTES));
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = mem_reg[rd_ptr_reg];
    assign enq        = push && !full;
    assign take       = deq && item_valid;

    always_comb
    begin
        count_next = count_reg;
        if (enq && !take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (take && !enq)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (enq)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ----- rtl/core/tfc_exec.sv -----
module tfc_exec (
    input  logic             clk,
    input  logic             rst_n,
    input  tfc_pkg::cfg_t    cfg,
    input  logic             item_valid,
    input  tfc_pkg::item_t   item,
    output logic             deq,
    input  logic             res_full,
    output logic             res_push,
    output tfc_pkg::result_t result
);

    logic [31:0] seg_limit_reg;
    logic [31:0] seg_limit_next;
    logic [31:0] msg_limit_reg;
    logic [31:0] msg_limit_next;
    logic [31:0] acked_seg_reg;
    logic [31:0] acked_seg_next;
    logic        xon_reg;
    logic        xon_next;
    logic [31:0] int_limit_reg;
    logic [31:0] int_limit_next;
    logic [31:0] int_next_reg;
    logic [31:0] int_next_next;
    logic        ok;
    logic [2:0]  status;
    logic        credit_ok;
    logic [33:0] want_seg;
    logic [33:0] seg_floor;
    logic [33:0] seg_ceil;
    logic [32:0] want_msg;
    logic [32:0] msg_ceil;
    logic [31:0] window_max;

    assign deq      = item_valid && !res_full;
    assign res_push = deq;

    always_comb
    begin
        want_seg   = {2'b00, seg_limit_reg} + {{26{item.delta[7]}}, item.delta};
        seg_floor  = {2'b00, acked_seg_reg};
        seg_ceil   = {2'b00, acked_seg_reg} + 34'(tfc_pkg::CREDIT_SPAN);
        want_msg   = {1'b0, msg_limit_reg} + {25'd0, item.delta};
        msg_ceil   = {1'b0, acked_seg_reg} + 33'(tfc_pkg::CREDIT_SPAN);
        window_max = (item.queue_empty ? 32'd0 : item.base)
                     + {24'd0, cfg.window_size} - 32'd1;

        seg_limit_next = seg_limit_reg;
        msg_limit_next = msg_limit_reg;
        acked_seg_next = acked_seg_reg;
        xon_next       = xon_reg;
        int_limit_next = int_limit_reg;
        int_next_next  = int_next_reg;
        ok             = 1'b0;
        status         = tfc_pkg::ST_OK;
        credit_ok      = 1'b1;

        case (item.cmd)
            tfc_pkg::CMD_CREDIT:
            begin
                if (item.kind == tfc_pkg::KIND_INT)
                begin
                    if (item.delta_neg)
                    begin
                        status = tfc_pkg::ST_BAD_CREDIT;
                    end
                    else
                    begin
                        int_limit_next = int_limit_reg + {24'd0, item.delta};
                        ok             = 1'b1;
                    end
                end
                else if (item.kind != tfc_pkg::KIND_DATA)
                begin
                    status = tfc_pkg::ST_IGNORED;
                end
                else
                begin
                    if (cfg.flow_mode == tfc_pkg::FLOW_MSG)
                    begin
                        if (item.delta_neg || (want_msg >= msg_ceil))
                        begin
                            credit_ok = 1'b0;
                        end
                        else
                        begin
                            msg_limit_next = want_msg[31:0];
                        end
                    end
                    else if (cfg.flow_mode == tfc_pkg::FLOW_SEG)
                    begin
                        if (($signed(want_seg) < $signed(seg_floor))
                            || ($signed(want_seg) >= $signed(seg_ceil)))
                        begin
                            credit_ok = 1'b0;
                        end
                        else
                        begin
                            seg_limit_next = want_seg[31:0];
                        end
                    end
                    if (credit_ok)
                    begin
                        ok = 1'b1;
                        if (item.modifier == tfc_pkg::MOD_XOFF)
                        begin
                            xon_next = 1'b0;
                        end
                        else if (item.modifier == tfc_pkg::MOD_XON)
                        begin
                            xon_next = 1'b1;
                        end
                    end
                    else
                    begin
                        status = tfc_pkg::ST_BAD_CREDIT;
                    end
                end
            end
            tfc_pkg::CMD_ACK:
            begin
                acked_seg_next = item.acked;
                ok             = 1'b1;
            end
            tfc_pkg::CMD_CHECK:
            begin
                if (!item.is_data)
                begin
                    ok = 1'b1;
                end
                else if (!xon_reg || (item.seg > window_max)
                         || ((cfg.flow_mode == tfc_pkg::FLOW_SEG)
                             && (item.seg > seg_limit_reg))
                         || ((cfg.flow_mode == tfc_pkg::FLOW_MSG)
                             && (item.msg > msg_limit_reg)))
                begin
                    status = tfc_pkg::ST_BLOCKED;
                end
                else
                begin
                    ok = 1'b1;
                end
            end
            tfc_pkg::CMD_INTR:
            begin
                if (item.too_long)
                begin
                    status = tfc_pkg::ST_TOO_LONG;
                end
                else if (int_limit_reg < int_next_reg)
                begin
                    status = tfc_pkg::ST_BLOCKED;
                end
                else
                begin
                    int_next_next = int_next_reg + 32'd1;
                    ok            = 1'b1;
                end
            end
            default:
            begin
                status = tfc_pkg::ST_OK;
            end
        endcase

        result.allowed   = ok;
        result.status    = status;
        result.seg_limit = seg_limit_next;
        result.msg_limit = msg_limit_next;
        result.int_limit = int_limit_next;
        result.xon       = xon_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_limit_reg <= 32'd0;
            msg_limit_reg <= 32'd0;
            acked_seg_reg <= 32'd0;
            xon_reg       <= 1'b1;
            int_limit_reg <= 32'd0;
            int_next_reg  <= 32'd1;
        end
        else if (deq)
        begin
            seg_limit_reg <= seg_limit_next;
            msg_limit_reg <= msg_limit_next;
            acked_seg_reg <= acked_seg_next;
            xon_reg       <= xon_next;
            int_limit_reg <= int_limit_next;
            int_next_reg  <= int_next_next;
        end
    end

endmodule

// ----- rtl/core/tfc_resq.sv -----
module tfc_resq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  tfc_pkg::result_t res_in,
    output logic             res_full,
    input  logic             pop,
    output logic             empty,
    output tfc_pkg::result_t res_out
);

    tfc_pkg::result_t mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             enq;
    logic             take;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign res_out  = mem_reg[rd_ptr_reg];
    assign enq      = res_push && !res_full;
    assign take     = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (enq && !take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (take && !enq)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (enq)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            mem_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

// ----- rtl/core/transport_flow_credit_gate.sv -----
// Transmit-side credit gate of a transport connection.
// Commands enter through a queue-style input: a transaction is taken at a rising
// edge with push high and full low. Each command yields exactly one result,
// read from a queue-style output: the oldest result is on the result ports while
// empty is low, and pop with empty low takes it.
// Configuration is written through cfg_we, cfg_index and cfg_data, one register
// per edge with no wait; the user must write it only while no command is in
// flight, and the block itself does not enforce this. A command accepted at an
// edge is decoded into a two-entry input queue, executed against the credit
// state when at its head with room in the result queue, and its result is
// registered there. The block takes one command per cycle while results are
// popped; the execute stage, which updates the credit counters, sets that rate.
// When the receiver stops popping, the two-entry result queue fills, then the
// two-entry input queue fills and full rises; no result is lost or repeated.
// Reset empties both queues, sets flow mode to none and the window size to
// eight, clears all credit limits and the acknowledged segment, turns
// transmission on and sets the next interrupt count to one.
module transport_flow_credit_gate (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        command,
    input  logic [1:0]        credit_kind,
    input  logic signed [7:0] credit_delta,
    input  logic [1:0]        credit_modifier,
    input  logic [31:0]       acked_segment,
    input  logic [31:0]       segment_count,
    input  logic [31:0]       message_count,
    input  logic              is_data,
    input  logic [31:0]       window_base,
    input  logic              queue_empty,
    input  logic [15:0]       interrupt_length,
    output logic              empty,
    input  logic              pop,
    output logic              allowed,
    output logic [2:0]        status,
    output logic [31:0]       segment_limit,
    output logic [31:0]       message_limit,
    output logic [31:0]       interrupt_limit,
    output logic              transmit_on
);

    tfc_pkg::cfg_t    cfg_reg;
    tfc_pkg::item_t   item;
    tfc_pkg::result_t res_in;
    tfc_pkg::result_t res_out;
    logic             item_valid;
    logic             deq;
    logic             res_push;
    logic             res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flow_mode   <= tfc_pkg::FLOW_MODE_RESET;
            cfg_reg.window_size <= tfc_pkg::WINDOW_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tfc_pkg::REG_FLOW_MODE:
                begin
                    cfg_reg.flow_mode <= cfg_data[1:0];
                end
                tfc_pkg::REG_WINDOW_SIZE:
                begin
                    cfg_reg.window_size <= cfg_data;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    tfc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .command          (command),
        .credit_kind      (credit_kind),
        .credit_delta     (credit_delta),
        .credit_modifier  (credit_modifier),
        .acked_segment    (acked_segment),
        .segment_count    (segment_count),
        .message_count    (message_count),
        .is_data          (is_data),
        .window_base      (window_base),
        .queue_empty      (queue_empty),
        .interrupt_length (interrupt_length),
        .deq              (deq),
        .item_valid       (item_valid),
        .item             (item)
    );

    tfc_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .deq        (deq),
        .res_full   (res_full),
        .res_push   (res_push),
        .result     (res_in)
    );

    tfc_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_out  (res_out)
    );

    assign allowed         = res_out.allowed;
    assign status          = res_out.status;
    assign segment_limit   = res_out.seg_limit;
    assign message_limit   = res_out.msg_limit;
    assign interrupt_limit = res_out.int_limit;
    assign transmit_on     = res_out.xon;

endmodule

// ----- rtl/core/tfc_checker.sv -----
module tfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        allowed,
    input logic [2:0]  status
);

    // A result is allowed exactly when its status reports success.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (allowed == (status == tfc_pkg::ST_OK)))
    else $error("allowed and status disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= tfc_pkg::ST_TOO_LONG))
    else $error("status code out of range");

    // The input side backs up only behind a stalled result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
    else $error("input full while no result waits");

    // With nothing waiting and no recent transaction, no result can appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !(push && !full) && !$past(push && !full)) |=> empty)
    else $error("result appeared without a transaction");

endmodule

bind transport_flow_credit_gate tfc_checker u_tfc_checker (.*);
